### sv/fpsqrt_pkg.sv
package fpsqrt_pkg;

    localparam int RAD_W         = 32;
    localparam int FMT_W         = 5;
    localparam int ROOT_W        = 31;
    localparam int HALF_W        = 4;
    localparam int STEPS         = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int WIDE_W        = 2 * ROOT_W + 1;

    localparam logic [RAD_W-1:0] TRIAL_BASE = 32'h4000_0001;

    typedef logic [ROOT_W-1:0] acc_t;
    typedef logic [ROOT_W-1:0] rem_t;
    typedef logic [HALF_W-1:0] half_t;

    function automatic acc_t step_trial(input int k);
        logic [RAD_W-1:0] t;
        t = TRIAL_BASE >> (2 * k);
        return t[ROOT_W-1:0];
    endfunction

endpackage

### sv/fixed_point_square_root_core.sv
// Fixed-point square root, Q15 result. Drive radicand (signed) and frac_bits
// with start; busy never rises, so a new word is taken every cycle. The root
// appears on root_q15 with done high for one cycle, after passing through
// one input register, one register per step of the 16-step digit-by-digit
// root, and one output register. There is no way to hold results off, so
// sample root_q15 whenever done is high. A negative radicand gives zero; an
// odd format is lowered by one and the radicand halved before the root is
// taken.
module fixed_point_square_root_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fpsqrt_pkg::RAD_W-1:0]    radicand,
    input  logic [fpsqrt_pkg::FMT_W-1:0]    frac_bits,
    output logic                            done,
    output logic [fpsqrt_pkg::ROOT_W-1:0]   root_q15
);
    import fpsqrt_pkg::*;

    logic  vld_reg [0:STEPS];
    acc_t  acc_reg [0:STEPS];
    rem_t  rem_reg [0:STEPS];
    half_t half_reg[0:STEPS];
    logic  neg_reg [0:STEPS];

    acc_t  acc_next[1:STEPS];
    rem_t  rem_next[1:STEPS];
    rem_t  rem_first;

    logic              done_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;

    logic              accept;
    logic [ROOT_W:0]   acc_fin;
    logic [WIDE_W-1:0] wide;
    logic [FMT_W-1:0]  sh_amt;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 0: drop sign, fold odd format into the radicand
    always_comb
    begin
        if (radicand[RAD_W-1])
        begin
            rem_first = '0;
        end
        else if (frac_bits[0])
        begin
            rem_first = {1'b0, radicand[RAD_W-2:1]};
        end
        else
        begin
            rem_first = radicand[ROOT_W-1:0];
        end
    end

    // one root step per stage
    always_comb
    begin
        logic [ROOT_W:0] sum;
        acc_t            trial;
        for (int k = 0; k < STEPS; k++)
        begin
            trial = step_trial(k);
            sum   = {1'b0, trial} + {1'b0, acc_reg[k]};
            if (sum <= {1'b0, rem_reg[k]})
            begin
                rem_next[k+1] = rem_reg[k] - sum[ROOT_W-1:0];
                acc_next[k+1] = (acc_reg[k] >> 1) | trial;
            end
            else
            begin
                rem_next[k+1] = rem_reg[k];
                acc_next[k+1] = acc_reg[k] >> 1;
            end
        end
    end

    // round up, then align to the output format
    always_comb
    begin
        acc_fin = {1'b0, acc_reg[STEPS]} + {{ROOT_W{1'b0}},
                  (acc_reg[STEPS] < rem_reg[STEPS])};
        if ({1'b0, half_reg[STEPS]} <= FMT_W'(OUT_FRAC_BITS))
        begin
            sh_amt = FMT_W'(OUT_FRAC_BITS) - {1'b0, half_reg[STEPS]};
            wide   = {{(WIDE_W-ROOT_W-1){1'b0}}, acc_fin} << sh_amt;
        end
        else
        begin
            sh_amt = {1'b0, half_reg[STEPS]} - FMT_W'(OUT_FRAC_BITS);
            wide   = {{(WIDE_W-ROOT_W-1){1'b0}}, acc_fin} >> sh_amt;
        end
        root_next = wide[ROOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
            done_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg[0]  <= '0;
        rem_reg[0]  <= rem_first;
        half_reg[0] <= frac_bits[FMT_W-1:1];
        neg_reg[0]  <= radicand[RAD_W-1];
        for (int k = 0; k < STEPS; k++)
        begin
            acc_reg[k+1]  <= acc_next[k+1];
            rem_reg[k+1]  <= rem_next[k+1];
            half_reg[k+1] <= half_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
        end
        root_reg <= root_next;
    end

    assign done     = done_reg;
    assign root_q15 = root_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, STEPS + 2))
        else $error("result without a matching start");

    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(radicand[RAD_W-1], STEPS + 2) |-> root_q15 == '0)
        else $error("negative radicand gave a nonzero root");

    a_neg_stage: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STEPS] && neg_reg[STEPS] |->
            acc_reg[STEPS] == '0 && rem_reg[STEPS] == '0)
        else $error("negative radicand left residue in the last stage");

endmodule
